[rtl/core/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg: shared constants for the blur / Sobel edge frame unit
// Stage widths, default frame limits, config indices and request codes.
// ----------------------------------------------------------------------------
package bse_pkg;
  localparam int unsigned DefMaxRows = 256;
  localparam int unsigned DefMaxCols = 256;
  localparam int unsigned DimW  = 9;   // config register width
  localparam int unsigned PixW  = 8;
  localparam int unsigned BlurW = 12;  // 8.4
  localparam int unsigned MagW  = 15;  // 11.4
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegRows = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCols = 1'b1;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;
endpackage

[rtl/core/blur_sobel_edge_frame_unit.sv]
// ----------------------------------------------------------------------------
// blur_sobel_edge_frame_unit: 3x3 box blur, Sobel magnitude, peak normalize
// Frame store, two processing passes under one sequencer, read-out.
// ----------------------------------------------------------------------------
// Usage:
//  in_* channel: tdata = pixel_value, tuser = req_type (0 load, 1 read).
//  Loads arrive in raster order; the last load of the frame starts the
//  processing passes, during which in_tready stays low.
//  Blur pass: for each inner pixel, tap reads through one adder and one memory
//  read port, then a write with a constant-reciprocal scale. Sobel pass: for
//  each inner pixel, tap reads, squaring of gx and then gy, a 15-step
//  restoring square root through the shared add/compare unit, one write.
//  Each read goes through a 23-step restoring divider (m*255/peak) before
//  out_tvalid rises; a new read is taken only once the result is accepted.
//  Loads are accepted back to back while the output register is empty.
//  out_* channel: tdata = edge_pixel, tlast = frame_last. The result sits in
//  an output register; when the receiver stalls, the block holds it and
//  accepts no further transaction until it is taken.
//  Reset and any cfg write restart the frame: indices zero, peak zero,
//  loading phase. Stores have no reset and no clearing pass.
//  Sizes outside 3..MAX are saturated.
// ----------------------------------------------------------------------------
module blur_sobel_edge_frame_unit #(
  parameter int unsigned MAX_ROWS = bse_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS = bse_pkg::DefMaxCols
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,                  // [7:0] pixel_value
  input  logic in_tuser,                        // [0] req_type
  output logic out_tvalid,
  input  logic out_tready,
  output logic [7:0] out_tdata,                 // [7:0] edge_pixel
  output logic out_tlast,                       // frame_last
  input  logic cfg_wr_en,
  input  logic [bse_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bse_pkg::DimW-1:0] cfg_wdata
);
  import bse_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SQW = 2 * MagW + 2;   // squared sum width
  localparam int unsigned NW  = MagW + 8;       // m*255 width

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_BTAP  = 4'd1;  // blur tap read
  localparam logic [3:0] S_BWR   = 4'd2;
  localparam logic [3:0] S_GTAP  = 4'd3;  // sobel tap read
  localparam logic [3:0] S_GSQ   = 4'd4;  // gx^2
  localparam logic [3:0] S_GSQ2  = 4'd5;  // + gy^2
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;  // reading phase, idle
  localparam logic [3:0] S_RRD   = 4'd8;  // memory read latency
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [DimW-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW:0] nr;
  logic [CW:0] nc;
  logic [AW:0] load_idx_r;
  logic [RW:0] row_r;
  logic [CW:0] col_r;
  logic [3:0]  tap_r;         // 0..8 issue, 9 = last data
  logic [4:0]  step_r;
  logic [MagW-1:0] peak_r;

  // stores
  logic [PixW-1:0]  src_mem [DEPTH];
  logic [BlurW-1:0] blur_mem [DEPTH];
  logic [MagW-1:0]  mag_mem [DEPTH];
  logic [PixW-1:0]  src_q;
  logic [BlurW-1:0] blur_q;
  logic [MagW-1:0]  mag_q;

  // saturated sizes
  always_comb begin
    if (rows_cfg_r < DimW'(3)) nr = (RW+1)'(3);
    else if (32'(rows_cfg_r) > MAX_ROWS) nr = (RW+1)'(MAX_ROWS);
    else nr = (RW+1)'(rows_cfg_r);
    if (cols_cfg_r < DimW'(3)) nc = (CW+1)'(3);
    else if (32'(cols_cfg_r) > MAX_COLS) nc = (CW+1)'(MAX_COLS);
    else nc = (CW+1)'(cols_cfg_r);
  end

  logic [AW:0] total;
  assign total = (AW+1)'(nr * nc);

  logic border;
  assign border = (row_r == '0) || (col_r == '0) ||
                  (row_r == nr - 1'b1) || (col_r == nc - 1'b1);

  // tap address: row_r + dr, col_r + dc with dr,dc in -1..1
  logic [1:0] tdr, tdc;
  logic [RW:0] trow;
  logic [CW:0] tcol;
  logic [AW:0] tap_addr, pix_addr;
  always_comb begin
    tdr = 2'd1; tdc = 2'd1;
    unique case (tap_r)
      4'd0: begin tdr = 2'd0; tdc = 2'd0; end
      4'd1: begin tdr = 2'd0; tdc = 2'd1; end
      4'd2: begin tdr = 2'd0; tdc = 2'd2; end
      4'd3: begin tdr = 2'd1; tdc = 2'd0; end
      4'd4: begin tdr = 2'd1; tdc = 2'd1; end
      4'd5: begin tdr = 2'd1; tdc = 2'd2; end
      4'd6: begin tdr = 2'd2; tdc = 2'd0; end
      4'd7: begin tdr = 2'd2; tdc = 2'd1; end
      4'd8: begin tdr = 2'd2; tdc = 2'd2; end
      default: begin tdr = 2'd1; tdc = 2'd1; end
    endcase
    trow = row_r + (RW+1)'(tdr) - 1'b1;
    tcol = col_r + (CW+1)'(tdc) - 1'b1;
    tap_addr = (AW+1)'(trow * nc) + (AW+1)'(tcol);
    pix_addr = (AW+1)'(row_r * nc) + (AW+1)'(col_r);
  end

  // previous tap (whose data is arriving) and its kernel weights
  logic [3:0] ptap;
  assign ptap = tap_r - 4'd1;
  logic signed [2:0] kx, ky;
  always_comb begin
    kx = 3'sd0; ky = 3'sd0;
    unique case (ptap)
      4'd0: begin kx = -3'sd1; ky = -3'sd1; end
      4'd1: begin kx =  3'sd0; ky = -3'sd2; end
      4'd2: begin kx =  3'sd1; ky = -3'sd1; end
      4'd3: begin kx = -3'sd2; ky =  3'sd0; end
      4'd5: begin kx =  3'sd2; ky =  3'sd0; end
      4'd6: begin kx = -3'sd1; ky =  3'sd1; end
      4'd7: begin kx =  3'sd0; ky =  3'sd2; end
      4'd8: begin kx =  3'sd1; ky =  3'sd1; end
      default: begin kx = 3'sd0; ky = 3'sd0; end
    endcase
  end

  // accumulators
  logic [11:0] bsum_r;
  logic signed [16:0] gx_r, gy_r;
  logic [SQW-1:0] rad_r;      // radicand / remainder
  logic [MagW:0]  root_r;
  logic [NW-1:0]  quo_r;      // dividend shifted out / quotient in
  logic [MagW:0]  rem_r;
  logic [7:0]     out_data_r;
  logic           out_last_r, out_valid_r;

  // shared add/compare unit
  logic [SQW:0] alu_a, alu_b, alu_diff;
  logic alu_ge;
  always_comb begin
    alu_a = '0; alu_b = '0;
    unique case (state_r)
      S_ROOT: begin
        // root bit k = step_r - 1
        alu_a = {1'b0, rad_r};
        alu_b = (SQW+1)'({root_r, 2'b01}) << (2 * (step_r - 5'd1));
      end
      S_DIV: begin
        alu_a = (SQW+1)'({rem_r[MagW-1:0], quo_r[NW-1]});
        alu_b = (SQW+1)'(peak_r);
      end
      default: begin alu_a = '0; alu_b = '0; end
    endcase
    alu_diff = alu_a - alu_b;
    alu_ge = (alu_a >= alu_b);
  end

  logic signed [16:0] bsx;
  assign bsx = $signed({5'b0, blur_q});

  // one 17x17 squarer, gx in S_GSQ, gy in S_GSQ2
  logic signed [16:0] sq_in;
  logic signed [33:0] sq_prod;
  logic [SQW-1:0] gsq;
  assign sq_in = (state_r == S_GSQ) ? gx_r : gy_r;
  assign sq_prod = sq_in * sq_in;
  assign gsq = SQW'($unsigned(sq_prod));

  // blur scale: floor(sum*16/9) by reciprocal 7281/2^16 then one correction
  logic [15:0] bs16;
  logic [31:0] bprod;
  logic [BlurW:0] bq0;
  logic [15:0] brem;
  logic [BlurW-1:0] blur_val;
  always_comb begin
    bs16 = {bsum_r, 4'b0};
    bprod = 32'(bs16) * 32'd7281;
    bq0 = (BlurW+1)'(bprod >> 16);
    brem = bs16 - 16'(bq0 * 9);
    blur_val = (brem >= 16'd9) ? BlurW'(bq0 + 1'b1) : BlurW'(bq0);
  end

  logic mem_en_blur, mem_en_mag;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_tvalid && in_tready && in_tuser == REQ_LOAD &&
        load_idx_r < total)
      src_mem[load_idx_r[AW-1:0]] <= in_tdata;
    src_q <= src_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (mem_en_blur) blur_mem[pix_addr[AW-1:0]] <= border ? {src_q, 4'b0} : blur_val;
    blur_q <= blur_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (mem_en_mag) mag_mem[pix_addr[AW-1:0]] <= border ? '0 : MagW'(root_r);
    mag_q <= mag_mem[rd_addr];
  end
  assign mem_en_blur = (state_r == S_BWR);
  assign mem_en_mag  = (state_r == S_ROOT && (border || step_r == '0));
  always_comb begin
    if (state_r == S_WAIT || state_r == S_RRD || state_r == S_DIV || state_r == S_OUT)
      rd_addr = load_idx_r[AW-1:0];
    else if (state_r == S_BTAP && border) rd_addr = pix_addr[AW-1:0];
    else rd_addr = tap_addr[AW-1:0];
  end

  assign in_tready = !out_valid_r && (state_r == S_LOAD || state_r == S_WAIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  logic acc, last_pix, is_last_rd;
  assign acc = in_tvalid && in_tready;
  assign last_pix = (col_r == nc - 1'b1) && (row_r == nr - 1'b1);
  assign is_last_rd = (load_idx_r + 1'b1 >= total);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rows_cfg_r <= DimW'(256); cols_cfg_r <= DimW'(256);
      load_idx_r <= '0; row_r <= '0; col_r <= '0; tap_r <= '0; step_r <= '0;
      peak_r <= '0; out_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == RegRows) rows_cfg_r <= cfg_wdata;
      if (cfg_index == RegCols) cols_cfg_r <= cfg_wdata;
      state_r <= S_LOAD; load_idx_r <= '0; peak_r <= '0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_LOAD: if (acc && in_tuser == REQ_LOAD) begin
          if (load_idx_r + 1'b1 >= total) begin
            state_r <= S_BTAP; row_r <= '0; col_r <= '0; tap_r <= '0;
            bsum_r <= '0; peak_r <= '0;
          end
          load_idx_r <= load_idx_r + 1'b1;
        end
        S_BTAP: begin
          if (tap_r != 4'd0) bsum_r <= bsum_r + 12'(src_q);
          if (border) begin
            if (tap_r == 4'd1) state_r <= S_BWR;
            tap_r <= tap_r + 1'b1;
          end else if (tap_r == 4'd9) state_r <= S_BWR;
          else tap_r <= tap_r + 1'b1;
        end
        S_BWR: begin
          tap_r <= '0; bsum_r <= '0;
          if (col_r == nc - 1'b1) begin
            col_r <= '0;
            if (row_r == nr - 1'b1) begin
              row_r <= '0; gx_r <= '0; gy_r <= '0;
            end else row_r <= row_r + 1'b1;
          end else col_r <= col_r + 1'b1;
          state_r <= last_pix ? S_GTAP : S_BTAP;
        end
        S_GTAP: begin
          if (border) begin
            state_r <= S_ROOT; root_r <= '0; step_r <= '0;
          end else begin
            if (tap_r != 4'd0) begin
              gx_r <= gx_r + bsx * 17'(kx);
              gy_r <= gy_r + bsx * 17'(ky);
            end
            if (tap_r == 4'd9) state_r <= S_GSQ;
            else tap_r <= tap_r + 1'b1;
          end
        end
        S_GSQ: begin rad_r <= gsq; state_r <= S_GSQ2; end
        S_GSQ2: begin
          rad_r <= rad_r + gsq; root_r <= '0; step_r <= 5'(MagW);
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (!border && step_r != '0) begin
            // bit step: trial (4r+1)<<2k against remainder
            if (alu_ge) begin
              rad_r <= SQW'(alu_diff);
              root_r <= {root_r[MagW-1:0], 1'b1};
            end else root_r <= {root_r[MagW-1:0], 1'b0};
            step_r <= step_r - 1'b1;
          end else begin
            if (!border && MagW'(root_r) > peak_r) peak_r <= MagW'(root_r);
            tap_r <= '0; gx_r <= '0; gy_r <= '0;
            if (col_r == nc - 1'b1) begin
              col_r <= '0;
              row_r <= (row_r == nr - 1'b1) ? '0 : row_r + 1'b1;
            end else col_r <= col_r + 1'b1;
            state_r <= last_pix ? S_WAIT : S_GTAP;
            if (last_pix) load_idx_r <= '0;
          end
        end
        S_WAIT: if (acc && in_tuser == REQ_READ) state_r <= S_RRD;
        S_RRD: begin
          quo_r <= NW'({mag_q, 8'b0} - NW'(mag_q)); rem_r <= '0;
          step_r <= 5'(NW); state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r != '0) begin
            rem_r <= alu_ge ? (MagW+1)'(alu_diff) : (MagW+1)'(alu_a);
            quo_r <= {quo_r[NW-2:0], alu_ge};
            step_r <= step_r - 1'b1;
          end else state_r <= S_OUT;
        end
        S_OUT: begin
          out_data_r <= (peak_r == '0 || quo_r > NW'(255)) ?
                        ((peak_r == '0) ? 8'd0 : 8'd255) : quo_r[7:0];
          out_last_r <= is_last_rd; out_valid_r <= 1'b1;
          if (is_last_rd) begin
            load_idx_r <= '0; peak_r <= '0; state_r <= S_LOAD;
          end else begin
            load_idx_r <= load_idx_r + 1'b1; state_r <= S_WAIT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // border pixels stored with zero magnitude, so normalizing gives zero

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_LOAD || state_r == S_WAIT)) else $error("ready busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && !cfg_wr_en |=> out_valid_r) else $error("out dropped");
  a_no_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready) else $error("ready while full");
endmodule
